/* src/crsd_pkg.sv */
// Shared types, codes and microcode ROM of the column RLE sprite decoder.
// No dependencies; used by column_rle_sprite_decoder.
package crsd_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 11;
  localparam int ROW_W          = 11;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [CFG_DATA_W-1:0] WIDTH_RST  = 11'd320;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RST = 11'd200;

  localparam logic [7:0] COL_SKIP     = 8'hFF;
  localparam logic [7:0] COL_PLAIN    = 8'h00;
  localparam logic [7:0] COL_REPEAT   = 8'h80;
  localparam logic [7:0] REPEAT_BASE  = 8'hDF;
  localparam logic [7:0] TRANSLUCENT  = 8'd232;
  localparam logic [ROW_W-1:0] ROW_CAP = 11'h7FF;

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_FRAME = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_TYPE   = 3'd1,
    PH_COLLEN = 3'd2,
    PH_RUNLEN = 3'd3,
    PH_YOFF   = 3'd4,
    PH_VALUES = 3'd5,
    PH_DONE   = 3'd6
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [9:0] pixel_x;
    logic [9:0] pixel_y;
    logic [7:0] color_index;
    logic       translucent;
    logic       overlay_previous;
    logic       last_of_run;
  } out_beat_t;

  // Microcode
  typedef logic [1:0] step_t;

  typedef enum logic [1:0] {
    UOP_FETCH  = 2'd0,
    UOP_DECODE = 2'd1,
    UOP_EMIT   = 2'd2,
    UOP_NOP    = 2'd3
  } uop_t;

  typedef enum logic [1:0] {
    JC_NO_BEAT = 2'd0,  // no input beat this cycle
    JC_NO_EMIT = 2'd1,  // decoded byte produces nothing
    JC_MORE    = 2'd2,  // emit iterations remain
    JC_ALWAYS  = 2'd3
  } jcond_t;

  typedef struct packed {
    uop_t   op;
    jcond_t cond;
    step_t  target;  // taken when cond holds
    step_t  nxt;     // taken otherwise
  } ucode_t;

  localparam step_t ST_FETCH  = 2'd0;
  localparam step_t ST_DECODE = 2'd1;
  localparam step_t ST_EMIT   = 2'd2;
  localparam step_t ST_SPARE  = 2'd3;

  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    unique case (s)
      ST_FETCH:  w = '{op: UOP_FETCH,  cond: JC_NO_BEAT, target: ST_FETCH, nxt: ST_DECODE};
      ST_DECODE: w = '{op: UOP_DECODE, cond: JC_NO_EMIT, target: ST_FETCH, nxt: ST_EMIT};
      ST_EMIT:   w = '{op: UOP_EMIT,   cond: JC_MORE,    target: ST_EMIT,  nxt: ST_FETCH};
      ST_SPARE:  w = '{op: UOP_NOP,    cond: JC_ALWAYS,  target: ST_FETCH, nxt: ST_FETCH};
      default:   w = '{op: UOP_NOP,    cond: JC_ALWAYS,  target: ST_FETCH, nxt: ST_FETCH};
    endcase
    return w;
  endfunction

endpackage

/* src/column_rle_sprite_decoder.sv */
// Column-major RLE sprite frame decoder: bytes in, pixel/frame/error beats out.
// Depends on crsd_pkg (types, codes, microcode ROM).
//
//   channel | ports                          | carries
//   in      | in_valid, in_stall, in_data    | one encoded byte + frame start flag
//   out     | out_valid, out_stall, out_data | pixel write, frame begin or error
//   cfg     | cfg_we, cfg_index, cfg_wdata   | image_width (0), image_height (1)
//
// A three-step microprogram runs each byte: fetch, decode, then one emit step
// per result. A byte with no result goes from decode straight back to fetch;
// a repeat color gives N pixels (N up to 32) from the emit loop.
// Emit steps hold while the output register is full and stalled.
// rst_n is synchronous; after reset bytes are ignored until a frame start.
module column_rle_sprite_decoder #(
  parameter int MAX_WIDTH  = crsd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = crsd_pkg::MAX_HEIGHT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  crsd_pkg::in_beat_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output crsd_pkg::out_beat_t                out_data,
  input  logic                               cfg_we,
  input  logic [crsd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [crsd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = crsd_pkg::ROW_W;

  // sequencer
  crsd_pkg::step_t  pc_r, pc_nxt;
  crsd_pkg::ucode_t uw;

  // config
  logic [crsd_pkg::CFG_DATA_W-1:0] width_r, height_r;

  // decode state
  crsd_pkg::phase_t phase_r, phase_nxt;
  logic [WW-1:0]    col_r, col_nxt;
  logic [RW-1:0]    row_r, row_nxt;
  logic [7:0]       colleft_r, colleft_nxt;
  logic [7:0]       runleft_r, runleft_nxt;
  logic             rep_r, rep_nxt;
  logic [5:0]       pend_r, pend_nxt;
  logic             seen_r, seen_nxt;

  // latched byte and pending emission
  crsd_pkg::in_beat_t byte_r, byte_nxt;
  crsd_pkg::kind_t    ek_r, ek_nxt;
  logic [WW-1:0]      ex_r, ex_nxt;
  logic [7:0]         ec_r, ec_nxt;
  logic               eo_r, eo_nxt;
  logic [5:0]         iter_r, iter_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  crsd_pkg::out_beat_t out_r, out_nxt;

  // helpers
  logic [WW-1:0] wl, col_inc;
  logic          col_done;
  logic [7:0]    cl_take;
  logic [7:0]    rl_dec;
  logic [RW:0]   row_sum, row_p1;
  logic          fits_now, fits_next, out_busy, in_beat, cond_hit;

  assign uw       = crsd_pkg::ucode_rom(pc_r);
  assign in_stall = (uw.op != crsd_pkg::UOP_FETCH);
  assign in_beat  = in_valid && !in_stall;
  assign out_busy = out_valid_r && out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    if (32'(width_r) < MAX_WIDTH) wl = WW'(width_r);
    else wl = WW'(MAX_WIDTH);
  end

  assign col_inc  = col_r + WW'(1);
  assign col_done = (col_inc >= wl);
  assign cl_take  = (colleft_r != 8'd0) ? colleft_r - 8'd1 : 8'd0;
  assign rl_dec   = (runleft_r != 8'd0) ? runleft_r - 8'd1 : 8'd0;
  assign row_sum  = {1'b0, row_r} + (RW+1)'(byte_r.data_byte);
  assign row_p1   = {1'b0, row_r} + (RW+1)'(1);

  // a pixel lands only inside the image; rows only grow, so kept pixels are a prefix
  assign fits_now  = (row_r < height_r) && (32'(row_r) < MAX_HEIGHT) &&
                     (32'(ex_r) < MAX_WIDTH);
  assign fits_next = (row_p1 < {1'b0, height_r}) && (32'(row_p1) < MAX_HEIGHT);

  // sequencer next step
  always_comb begin
    unique case (uw.cond)
      crsd_pkg::JC_NO_BEAT: cond_hit = !in_beat;
      crsd_pkg::JC_NO_EMIT: cond_hit = (iter_nxt == 6'd0);
      crsd_pkg::JC_MORE:    cond_hit = (iter_nxt != 6'd0);
      crsd_pkg::JC_ALWAYS:  cond_hit = 1'b1;
      default:              cond_hit = 1'b1;
    endcase
    if (uw.op == crsd_pkg::UOP_EMIT && out_busy) pc_nxt = pc_r;
    else if (cond_hit) pc_nxt = uw.target;
    else pc_nxt = uw.nxt;
  end

  // datapath
  always_comb begin
    phase_nxt     = phase_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    colleft_nxt   = colleft_r;
    runleft_nxt   = runleft_r;
    rep_nxt       = rep_r;
    pend_nxt      = pend_r;
    seen_nxt      = seen_r;
    byte_nxt      = byte_r;
    ek_nxt        = ek_r;
    ex_nxt        = ex_r;
    ec_nxt        = ec_r;
    eo_nxt        = eo_r;
    iter_nxt      = iter_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (uw.op)
      crsd_pkg::UOP_FETCH: begin
        if (in_beat) byte_nxt = in_data;
      end

      crsd_pkg::UOP_DECODE: begin
        iter_nxt = 6'd0;
        ek_nxt   = crsd_pkg::KIND_PIXEL;
        ex_nxt   = col_r;
        ec_nxt   = byte_r.data_byte;
        eo_nxt   = 1'b0;
        if (byte_r.frame_start) begin
          ek_nxt      = crsd_pkg::KIND_FRAME;
          eo_nxt      = (byte_r.data_byte == 8'd0) && seen_r;
          iter_nxt    = 6'd1;
          seen_nxt    = 1'b1;
          col_nxt     = '0;
          row_nxt     = '0;
          colleft_nxt = 8'd0;
          runleft_nxt = 8'd0;
          rep_nxt     = 1'b0;
          pend_nxt    = 6'd0;
          phase_nxt   = (wl == '0) ? crsd_pkg::PH_DONE : crsd_pkg::PH_TYPE;
        end else begin
          unique case (phase_r)
            crsd_pkg::PH_TYPE: begin
              if (byte_r.data_byte == crsd_pkg::COL_SKIP) begin
                col_nxt   = col_inc;
                phase_nxt = col_done ? crsd_pkg::PH_DONE : crsd_pkg::PH_TYPE;
              end else if (byte_r.data_byte == crsd_pkg::COL_PLAIN ||
                           byte_r.data_byte == crsd_pkg::COL_REPEAT) begin
                rep_nxt   = (byte_r.data_byte == crsd_pkg::COL_REPEAT);
                phase_nxt = crsd_pkg::PH_COLLEN;
              end else begin
                ek_nxt    = crsd_pkg::KIND_ERROR;
                iter_nxt  = 6'd1;
                phase_nxt = crsd_pkg::PH_DONE;
              end
            end
            crsd_pkg::PH_COLLEN: begin
              colleft_nxt = (byte_r.data_byte >= 8'd2) ? byte_r.data_byte - 8'd2 : 8'd0;
              row_nxt     = '0;
              if (byte_r.data_byte <= 8'd2) begin
                col_nxt   = col_inc;
                phase_nxt = col_done ? crsd_pkg::PH_DONE : crsd_pkg::PH_TYPE;
              end else begin
                phase_nxt = crsd_pkg::PH_RUNLEN;
              end
            end
            crsd_pkg::PH_RUNLEN: begin
              colleft_nxt = cl_take;
              runleft_nxt = byte_r.data_byte;
              pend_nxt    = 6'd0;
              phase_nxt   = crsd_pkg::PH_YOFF;
            end
            crsd_pkg::PH_YOFF: begin
              colleft_nxt = cl_take;
              row_nxt     = row_sum[RW] ? crsd_pkg::ROW_CAP : row_sum[RW-1:0];
              if (runleft_r != 8'd0) begin
                phase_nxt = crsd_pkg::PH_VALUES;
              end else if (cl_take == 8'd0) begin
                col_nxt   = col_inc;
                phase_nxt = col_done ? crsd_pkg::PH_DONE : crsd_pkg::PH_TYPE;
              end else begin
                phase_nxt = crsd_pkg::PH_RUNLEN;
              end
            end
            crsd_pkg::PH_VALUES: begin
              colleft_nxt = cl_take;
              runleft_nxt = rl_dec;
              if (pend_r != 6'd0) begin
                iter_nxt = pend_r;
                pend_nxt = 6'd0;
              end else if (rep_r && byte_r.data_byte > crsd_pkg::REPEAT_BASE) begin
                // repeat code: color follows in the next byte
                if (rl_dec != 8'd0) pend_nxt = 6'(byte_r.data_byte - crsd_pkg::REPEAT_BASE);
              end else begin
                iter_nxt = 6'd1;
              end
              if (rl_dec == 8'd0) begin
                pend_nxt = 6'd0;
                if (cl_take == 8'd0) begin
                  col_nxt   = col_inc;
                  phase_nxt = col_done ? crsd_pkg::PH_DONE : crsd_pkg::PH_TYPE;
                end else begin
                  phase_nxt = crsd_pkg::PH_RUNLEN;
                end
              end
            end
            default: ;
          endcase
        end
      end

      crsd_pkg::UOP_EMIT: begin
        if (!out_busy) begin
          if (ek_r == crsd_pkg::KIND_PIXEL) begin
            if (fits_now) begin
              out_valid_nxt            = 1'b1;
              out_nxt.result_kind      = crsd_pkg::KIND_PIXEL;
              out_nxt.pixel_x          = 10'(ex_r);
              out_nxt.pixel_y          = row_r[9:0];
              out_nxt.color_index      = ec_r;
              out_nxt.translucent      = (ec_r == crsd_pkg::TRANSLUCENT);
              out_nxt.overlay_previous = 1'b0;
              out_nxt.last_of_run      = (iter_r == 6'd1) || !fits_next;
            end
            if (row_r != crsd_pkg::ROW_CAP) row_nxt = row_p1[RW-1:0];
            iter_nxt = iter_r - 6'd1;
          end else begin
            out_valid_nxt            = 1'b1;
            out_nxt.result_kind      = ek_r;
            out_nxt.pixel_x          = 10'd0;
            out_nxt.pixel_y          = 10'd0;
            out_nxt.color_index      = 8'd0;
            out_nxt.translucent      = 1'b0;
            out_nxt.overlay_previous = eo_r;
            out_nxt.last_of_run      = 1'b1;
            iter_nxt                 = 6'd0;
          end
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= crsd_pkg::ST_FETCH;
      width_r     <= crsd_pkg::WIDTH_RST;
      height_r    <= crsd_pkg::HEIGHT_RST;
      phase_r     <= crsd_pkg::PH_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      colleft_r   <= 8'd0;
      runleft_r   <= 8'd0;
      rep_r       <= 1'b0;
      pend_r      <= 6'd0;
      seen_r      <= 1'b0;
      iter_r      <= 6'd0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      phase_r     <= phase_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      colleft_r   <= colleft_nxt;
      runleft_r   <= runleft_nxt;
      rep_r       <= rep_nxt;
      pend_r      <= pend_nxt;
      seen_r      <= seen_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == crsd_pkg::REG_IMAGE_WIDTH)  width_r  <= cfg_wdata;
      if (cfg_we && cfg_index == crsd_pkg::REG_IMAGE_HEIGHT) height_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    ek_r   <= ek_nxt;
    ex_r   <= ex_nxt;
    ec_r   <= ec_nxt;
    eo_r   <= eo_nxt;
    out_r  <= out_nxt;
  end

endmodule
